[rtl/mri_pkg.sv]
package mri_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STARTED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_T2_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_T3_TENTHS = 2'd2;

	// Field and counter widths
	localparam int SPEED_W   = 16;
	localparam int OFF_CNT_W = 12;
	localparam int ON_CNT_W  = 8;

	// Off-wait is programmed in tenths of the tick count
	localparam logic [OFF_CNT_W-1:0] OFF_WAIT_SCALE = 12'd10;

	// Two-bit two's complement sign
	typedef enum logic [1:0] {
		SIGN_ZERO = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd3
	} sign_t;

	// One result beat
	typedef struct packed {
		logic supply_on;
		logic direction_forward;
		logic busy_res;
	} res_t;

endpackage

[rtl/mri_seq.sv]
module mri_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mri_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [mri_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                accept,
	input  logic                                kind,
	input  logic signed [mri_pkg::SPEED_W-1:0]  speed,
	output mri_pkg::res_t                       res
);

	typedef enum logic [2:0] {
		PH_INIT     = 3'd1,
		PH_MONITOR  = 3'd2,
		PH_OFFWAIT  = 3'd3,
		PH_SETDIR   = 3'd4,
		PH_ONWAIT   = 3'd5,
		PH_SUPPLYON = 3'd6
	} phase_t;

	// Configuration
	logic                                started_q;
	logic [mri_pkg::ON_CNT_W-1:0]        t2_q;
	logic [mri_pkg::CFG_DATA_W-1:0]      t3_q;

	// Sequencer state
	phase_t                              phase_q, phase_d;
	mri_pkg::sign_t                      req_sign_q, req_sign_d;
	mri_pkg::sign_t                      run_sign_q, run_sign_d;
	logic [mri_pkg::OFF_CNT_W-1:0]       off_cnt_q, off_cnt_d;
	logic [mri_pkg::ON_CNT_W-1:0]        on_cnt_q, on_cnt_d;
	logic                                supply_q, supply_d;
	logic                                dir_q, dir_d;

	logic [mri_pkg::OFF_CNT_W-1:0]       off_load;
	logic                                on_wait_done;

	assign off_load = {{(mri_pkg::OFF_CNT_W-mri_pkg::CFG_DATA_W){1'b0}}, t3_q}
		* mri_pkg::OFF_WAIT_SCALE;

	// Next state for one beat; expired waits fall through in the same tick
	always_comb begin
		phase_d      = phase_q;
		req_sign_d   = req_sign_q;
		run_sign_d   = run_sign_q;
		off_cnt_d    = off_cnt_q;
		on_cnt_d     = on_cnt_q;
		supply_d     = supply_q;
		dir_d        = dir_q;
		on_wait_done = 1'b0;

		if (!kind) begin
			if (speed == '0)
				req_sign_d = mri_pkg::SIGN_ZERO;
			else if (speed[mri_pkg::SPEED_W-1])
				req_sign_d = mri_pkg::SIGN_NEG;
			else
				req_sign_d = mri_pkg::SIGN_POS;
		end else if (started_q) begin
			unique case (phase_q)
				PH_INIT: begin
					phase_d  = PH_MONITOR;
					supply_d = 1'b0;
				end
				PH_MONITOR: begin
					if (run_sign_q != req_sign_q) begin
						run_sign_d = req_sign_q;
						phase_d    = PH_OFFWAIT;
						off_cnt_d  = off_load;
						on_cnt_d   = t2_q;
						supply_d   = 1'b0;
					end
				end
				PH_OFFWAIT, PH_SETDIR: begin
					if (phase_q == PH_OFFWAIT && off_cnt_q != '0) begin
						off_cnt_d = off_cnt_q - 1'b1;
					end else begin
						// set direction, then on to the on-wait, or back to monitor for a zero sign
						dir_d = (run_sign_q == mri_pkg::SIGN_POS);
						if (run_sign_q == mri_pkg::SIGN_ZERO)
							phase_d = PH_MONITOR;
						else
							on_wait_done = 1'b1;
					end
				end
				PH_ONWAIT: on_wait_done = 1'b1;
				PH_SUPPLYON: begin
					supply_d = 1'b1;
					phase_d  = PH_MONITOR;
				end
				default: ;
			endcase

			// on-wait step, shared by direct entry and fall-through
			if (on_wait_done) begin
				if (on_cnt_q != '0) begin
					on_cnt_d = on_cnt_q - 1'b1;
					phase_d  = PH_ONWAIT;
				end else begin
					supply_d = 1'b1;
					phase_d  = PH_MONITOR;
				end
			end
		end
	end

	assign res.supply_on         = supply_d;
	assign res.direction_forward = dir_d;
	assign res.busy_res          = (phase_d != PH_MONITOR);

	// State and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			t2_q       <= '0;
			t3_q       <= '0;
			phase_q    <= PH_INIT;
			req_sign_q <= mri_pkg::SIGN_ZERO;
			run_sign_q <= mri_pkg::SIGN_ZERO;
			off_cnt_q  <= '0;
			on_cnt_q   <= '0;
			supply_q   <= 1'b0;
			dir_q      <= 1'b0;
		end else begin
			// writing started as 1 sends the sequencer back to init
			if (wr_en && wr_index == mri_pkg::CFG_STARTED && wr_data[0])
				phase_q <= PH_INIT;
			else if (accept)
				phase_q <= phase_d;
			if (accept) begin
				req_sign_q <= req_sign_d;
				run_sign_q <= run_sign_d;
				off_cnt_q  <= off_cnt_d;
				on_cnt_q   <= on_cnt_d;
				supply_q   <= supply_d;
				dir_q      <= dir_d;
			end
			if (wr_en) begin
				unique case (wr_index)
					mri_pkg::CFG_STARTED:   started_q <= wr_data[0];
					mri_pkg::CFG_T2_TICKS:  t2_q <= wr_data;
					mri_pkg::CFG_T3_TENTHS: t3_q <= wr_data;
					default: ;
				endcase
			end
		end
	end

endmodule

[rtl/mri_out.sv]
module mri_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          accept,
	input  mri_pkg::res_t res,
	output logic          out_valid,
	input  logic          out_ready,
	output mri_pkg::res_t res_out
);

	logic          valid_s1;
	mri_pkg::res_t res_s1;

	// Take a new beat whenever the result slot is empty or draining
	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_s1 <= res;
	end

	assign out_valid = valid_s1;
	assign res_out   = res_s1;

endmodule

[rtl/motor_reversal_interlock_core.sv]
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while out_ready is high; the result register frees as it is read.
// The sequencer next state is one pass of compare/decrement logic per beat.
// arst_n clears config, sequencer (init phase, zero signs/counters, outputs
// low) and the result valid bit; the block takes beats right after reset.
module motor_reversal_interlock_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mri_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [mri_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic signed [mri_pkg::SPEED_W-1:0]  speed,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                supply_on,
	output logic                                direction_forward,
	output logic                                busy_res
);

	logic          accept;
	mri_pkg::res_t res_next;
	mri_pkg::res_t res_out;

	mri_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.accept   (accept),
		.kind     (kind),
		.speed    (speed),
		.res      (res_next)
	);

	mri_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.accept    (accept),
		.res       (res_next),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign supply_on         = res_out.supply_on;
	assign direction_forward = res_out.direction_forward;
	assign busy_res          = res_out.busy_res;

endmodule

[rtl/mri_chk.sv]
module mri_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic supply_on,
	input logic direction_forward,
	input logic busy_res
);

	// Input side stalls only behind a held result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not track the result slot");

	// Every accepted beat yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted beat produced no result");

	// No result without an input beat
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !in_valid) |=> !out_valid)
		else $error("result appeared without an input beat");

	// A stalled result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(supply_on)
			&& $stable(direction_forward) && $stable(busy_res)))
		else $error("stalled result changed");

endmodule

bind motor_reversal_interlock_core mri_chk u_mri_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.supply_on         (supply_on),
	.direction_forward (direction_forward),
	.busy_res          (busy_res)
);

[tb/tb_motor_reversal_interlock_core.sv]
module tb_motor_reversal_interlock_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	// Beat kinds and the register index the block does not decode
	localparam logic KIND_SETPOINT = 1'b0;
	localparam logic KIND_TICK     = 1'b1;
	localparam logic [mri_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Sequencer phases as the interlock walks them
	typedef enum logic [2:0] {
		SEQ_INIT      = 3'd1,
		SEQ_MONITOR   = 3'd2,
		SEQ_OFF_WAIT  = 3'd3,
		SEQ_SET_DIR   = 3'd4,
		SEQ_ON_WAIT   = 3'd5,
		SEQ_SUPPLY_ON = 3'd6
	} seq_phase_t;

	typedef struct packed {
		logic                               kind;
		logic signed [mri_pkg::SPEED_W-1:0] speed;
	} cmd_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               wr_en = 1'b0;
	logic [mri_pkg::CFG_IDX_W-1:0]      wr_index = '0;
	logic [mri_pkg::CFG_DATA_W-1:0]     wr_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic                               kind = 1'b0;
	logic signed [mri_pkg::SPEED_W-1:0] speed = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               supply_on;
	logic                               direction_forward;
	logic                               busy_res;

	// Shadow of the interlock: configuration and sequencer state
	logic                          cfg_started = 1'b0;
	logic [7:0]                    cfg_t2 = '0;
	logic [7:0]                    cfg_t3 = '0;
	seq_phase_t                    seq = SEQ_INIT;
	mri_pkg::sign_t                req_sign = mri_pkg::SIGN_ZERO;
	mri_pkg::sign_t                run_sign = mri_pkg::SIGN_ZERO;
	logic [mri_pkg::OFF_CNT_W-1:0] off_cnt = '0;
	logic [mri_pkg::ON_CNT_W-1:0]  on_cnt = '0;
	logic                          supply_lvl = 1'b0;
	logic                          dir_lvl = 1'b0;

	cmd_t          cmd_queue[$];
	mri_pkg::res_t expected_levels[$];
	bit            had_error = 1'b0;
	bit            steady = 1'b0;
	int unsigned   gap_left = 0;
	int unsigned   stall_left = 0;
	int unsigned   cycle_count = 0;

	motor_reversal_interlock_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.speed            (speed),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.supply_on        (supply_on),
		.direction_forward(direction_forward),
		.busy_res         (busy_res)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Apply one beat to the shadow sequencer and return the drive levels after it
	function automatic mri_pkg::res_t step_interlock(input logic k,
		input logic signed [mri_pkg::SPEED_W-1:0] spd);
		mri_pkg::res_t lv;
		bit            hold;
		hold = 1'b0;
		if (k == KIND_SETPOINT) begin
			if (spd == 0)
				req_sign = mri_pkg::SIGN_ZERO;
			else if (spd[mri_pkg::SPEED_W-1])
				req_sign = mri_pkg::SIGN_NEG;
			else
				req_sign = mri_pkg::SIGN_POS;
		end else if (cfg_started) begin
			if (seq == SEQ_INIT) begin
				seq = SEQ_MONITOR;
				supply_lvl = 1'b0;
			end else if (seq == SEQ_MONITOR) begin
				if (run_sign != req_sign) begin
					run_sign = req_sign;
					seq = SEQ_OFF_WAIT;
					off_cnt = mri_pkg::OFF_WAIT_SCALE * {4'd0, cfg_t3};
					on_cnt = cfg_t2;
					supply_lvl = 1'b0;
				end
			end else begin
				// expired waits fall through to the next phase in the same tick
				if (seq == SEQ_OFF_WAIT) begin
					if (off_cnt != 0) begin
						off_cnt = off_cnt - 1'b1;
						hold = 1'b1;
					end else
						seq = SEQ_SET_DIR;
				end
				if (!hold && seq == SEQ_SET_DIR) begin
					dir_lvl = (run_sign == mri_pkg::SIGN_POS);
					if (run_sign == mri_pkg::SIGN_ZERO) begin
						seq = SEQ_MONITOR;
						hold = 1'b1;
					end else
						seq = SEQ_ON_WAIT;
				end
				if (!hold && seq == SEQ_ON_WAIT) begin
					if (on_cnt != 0) begin
						on_cnt = on_cnt - 1'b1;
						hold = 1'b1;
					end else
						seq = SEQ_SUPPLY_ON;
				end
				if (!hold && seq == SEQ_SUPPLY_ON) begin
					supply_lvl = 1'b1;
					seq = SEQ_MONITOR;
				end
			end
		end
		lv.supply_on = supply_lvl;
		lv.direction_forward = dir_lvl;
		lv.busy_res = (seq != SEQ_MONITOR);
		return lv;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Speed with a random sign; magnitudes spread over the whole field
	function automatic logic signed [mri_pkg::SPEED_W-1:0] rand_speed();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return mri_pkg::SPEED_W'($urandom_range(1, 32767));
			default: return mri_pkg::SPEED_W'($urandom) | 16'sh8000;
		endcase
	endfunction

	task automatic push_cmd(input logic k, input logic signed [mri_pkg::SPEED_W-1:0] spd);
		cmd_t c;
		c.kind = k;
		c.speed = spd;
		cmd_queue.push_back(c);
	endtask

	// Ticks carry a random speed, which the block must ignore
	task automatic push_ticks(input int unsigned n);
		repeat (n) push_cmd(KIND_TICK, mri_pkg::SPEED_W'($urandom));
	endtask

	task automatic write_reg(input logic [mri_pkg::CFG_IDX_W-1:0] idx,
		input logic [mri_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			mri_pkg::CFG_STARTED: begin
				cfg_started = val[0];
				if (val[0])
					seq = SEQ_INIT;
			end
			mri_pkg::CFG_T2_TICKS:  cfg_t2 = val;
			mri_pkg::CFG_T3_TENTHS: cfg_t3 = val;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Block is idle once nothing is queued, in flight or owed
	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || in_valid || expected_levels.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	// Input driver: predicts each accepted beat, then offers the next one
	always @(posedge clk) begin : drv_blk
		cmd_t next_cmd;
		bit   fire;
		fire = in_valid && in_ready;
		if (fire)
			expected_levels.push_back(step_interlock(kind, speed));
		if (arst_n && (!in_valid || fire)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				next_cmd = cmd_queue.pop_front();
				in_valid <= 1'b1;
				kind <= next_cmd.kind;
				speed <= next_cmd.speed;
				gap_left <= pick_gap();
			end else
				in_valid <= 1'b0;
		end
	end

	// Result monitor and receiver stalls
	always @(posedge clk) begin : mon_blk
		mri_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				$error("result beat with nothing expected");
				had_error = 1'b1;
			end else begin
				want = expected_levels.pop_front();
				if (supply_on !== want.supply_on) begin
					$error("supply_on: expected %0b, got %0b", want.supply_on, supply_on);
					had_error = 1'b1;
				end
				if (direction_forward !== want.direction_forward) begin
					$error("direction_forward: expected %0b, got %0b",
						want.direction_forward, direction_forward);
					had_error = 1'b1;
				end
				if (busy_res !== want.busy_res) begin
					$error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
					had_error = 1'b1;
				end
			end
		end
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 5) == 0)
				stall_left <= pick_gap();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_motor_reversal_interlock_core: errors");
			$finish;
		end
	end

	initial begin : stim_blk
		int unsigned span;
		int unsigned n_items;
		int unsigned n_ticks;
		logic [7:0]  t2_pick;
		logic [7:0]  t3_pick;
		bit          run;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Not started: ticks do nothing, set-points are still stored
		push_cmd(KIND_TICK, 16'sd0);
		push_cmd(KIND_SETPOINT, 16'sh7FFF);
		push_cmd(KIND_SETPOINT, 16'sh8000);
		push_cmd(KIND_TICK, 16'shFFFF);
		push_cmd(KIND_SETPOINT, -16'sd1);
		wait_drained();
		write_reg(CFG_SPARE, 8'hFF);
		write_reg(mri_pkg::CFG_T2_TICKS, 8'd0);
		write_reg(mri_pkg::CFG_T3_TENTHS, 8'd0);
		write_reg(mri_pkg::CFG_STARTED, 8'h01);
		end_writes();

		// Zero waits: leave init, reverse, whole chain in one tick
		push_ticks(3);
		push_cmd(KIND_SETPOINT, 16'sd1);
		push_ticks(2);
		push_cmd(KIND_SETPOINT, 16'sd0);
		push_ticks(2);
		wait_drained();

		// Stop in the middle of the off wait: phase and outputs freeze
		write_reg(mri_pkg::CFG_T3_TENTHS, 8'd1);
		write_reg(mri_pkg::CFG_T2_TICKS, 8'd2);
		end_writes();
		push_cmd(KIND_SETPOINT, 16'sd100);
		push_ticks(4);
		wait_drained();
		write_reg(mri_pkg::CFG_STARTED, 8'hFE);
		end_writes();
		push_ticks(2);
		push_cmd(KIND_SETPOINT, -16'sd5);
		wait_drained();

		// Restart goes back through init
		write_reg(mri_pkg::CFG_STARTED, 8'h01);
		end_writes();
		push_ticks(16);
		wait_drained();

		// Largest off-wait load, cut short by a restart
		write_reg(mri_pkg::CFG_T2_TICKS, 8'hFF);
		write_reg(mri_pkg::CFG_T3_TENTHS, 8'hFF);
		write_reg(mri_pkg::CFG_STARTED, 8'hFF);
		end_writes();
		push_cmd(KIND_SETPOINT, 16'sd300);
		push_ticks(40);
		wait_drained();

		// Full on wait right after the direction is set
		write_reg(mri_pkg::CFG_T3_TENTHS, 8'd0);
		write_reg(mri_pkg::CFG_STARTED, 8'h01);
		end_writes();
		push_cmd(KIND_SETPOINT, -16'sd7);
		push_ticks(262);
		wait_drained();

		// Random phases: reversal sequences with random content, plus noise
		for (int p = 0; p < 7; p++) begin
			steady = ($urandom_range(0, 3) == 0);
			t2_pick = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
			t3_pick = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 12))
				: 8'($urandom_range(0, 2));
			run = ($urandom_range(0, 5) != 0);
			write_reg(mri_pkg::CFG_T2_TICKS, t2_pick);
			write_reg(mri_pkg::CFG_T3_TENTHS, t3_pick);
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_SPARE, 8'($urandom));
			if (!cfg_started || !run || $urandom_range(0, 2) == 0)
				write_reg(mri_pkg::CFG_STARTED, {7'($urandom), run});
			end_writes();

			n_items = 0;
			while (n_items < 90) begin
				if ($urandom_range(0, 9) < 8) begin
					push_cmd(KIND_SETPOINT, rand_speed());
					span = 10 * t3_pick + t2_pick + 3;
					// a quarter of the sequences are cut short by the next set-point
					if ($urandom_range(0, 3) == 0)
						n_ticks = $urandom_range(0, span);
					else
						n_ticks = span + $urandom_range(0, 3);
					push_ticks(n_ticks);
					n_items += 1 + n_ticks;
				end else begin
					n_ticks = $urandom_range(1, 4);
					repeat (n_ticks) push_cmd(1'($urandom), mri_pkg::SPEED_W'($urandom));
					n_items += n_ticks;
				end
			end
			wait_drained();
		end

		steady = 1'b0;
		repeat (4) @(posedge clk);
		if (!had_error)
			$display("tb_motor_reversal_interlock_core: clean");
		else
			$display("tb_motor_reversal_interlock_core: errors");
		$finish;
	end

endmodule
